// ===== rtl/p2pps_pkg.sv =====
// Shared types and constants for the point-to-point profile sampler.
package p2pps_pkg;

	localparam int SAMPLE_LIMIT = 1024;
	localparam int AXES         = 6;

	localparam int D_W        = $clog2(SAMPLE_LIMIT);
	localparam int N_W        = 11;
	localparam int VMAX_W     = 31;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int AXIS_W     = 3;

	localparam int RECIP_K     = 45;
	localparam int RECIP_W     = RECIP_K + 1;
	localparam int FRAC_BITS   = 24;
	localparam int T_W         = FRAC_BITS + 1;
	localparam int RECIP_SHIFT = RECIP_K - FRAC_BITS;
	localparam int U_W         = 23;
	localparam int SR_W        = 26;
	localparam int M_W         = 47;

	localparam logic [D_W-1:0] D_RESET = D_W'(99);
	localparam logic [RECIP_W-1:0] RECIP_RESET =
		RECIP_W'((64'd1 << RECIP_K) / 64'(D_RESET) + 64'd1);

	localparam logic [T_W-1:0] FRAC_ONE  = T_W'(1) << FRAC_BITS;
	localparam logic [T_W-1:0] RAMP_EDGE = T_W'(5033165);
	localparam logic [T_W-1:0] FLAT_END  = FRAC_ONE - RAMP_EDGE;
	localparam logic [U_W-1:0] SHAPE_DIV = U_W'(5033165);
	localparam logic [SR_W-1:0] SHAPE_RECIP =
		SR_W'((64'd1 << (2 * FRAC_BITS)) / 64'd5033165);

	localparam logic [VMAX_W-1:0] MIN_SPEED = VMAX_W'(655);
	localparam logic [31:0]       MIN_DIST  = 32'd65;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VMAX_FIRST   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VMAX_LAST    = 3'd6;

	typedef struct packed {
		logic [AXIS_W-1:0] axis;
		logic [D_W-1:0]    point_index;
		logic signed [31:0] start_position;
		logic signed [31:0] end_position;
		logic [31:0]       start_time;
		logic [31:0]       end_time;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic [31:0]        time_ms;
	} point_t;

endpackage

// ===== rtl/p2pps_recip.sv =====
// Bit-serial reciprocal of the point step: floor(2^45 / divisor) + 1.
module p2pps_recip import p2pps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [D_W-1:0]     divisor,
	output logic               busy,
	output logic [RECIP_W-1:0] recip
);

	localparam int STEP_W = $clog2(RECIP_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RECIP_W - 1);

	logic               busy_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [D_W-1:0]     div_q;
	logic [D_W-1:0]     rem_q;
	logic [RECIP_W-1:0] quo_q;
	logic [RECIP_W-1:0] recip_q;

	logic [D_W:0]       rem_sh;
	logic               ge;
	logic [D_W-1:0]     rem_nx;
	logic [RECIP_W-1:0] quo_nx;

	// dividend is a single one at the top bit
	always_comb begin
		rem_sh = {rem_q, (cnt_q == '0)};
		ge     = rem_sh >= {1'b0, div_q};
		rem_nx = ge ? D_W'(rem_sh - {1'b0, div_q}) : rem_sh[D_W-1:0];
		quo_nx = {quo_q[RECIP_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			recip_q <= RECIP_RESET;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q  <= 1'b0;
				recip_q <= quo_nx + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign busy  = busy_q;
	assign recip = recip_q;

endmodule

// ===== rtl/point_to_point_profile_sampler.sv =====
// Top level: five-stage sampler of position, velocity and time for one move point.
//
//   channel  direction  payload           transaction when
//   sample   in         sample_t          sample_valid & sample_ready
//   point    out        point_t           point_valid & point_ready
//   cfg      in         cfg_index/data    cfg_valid & cfg_ready
//
// One sample per cycle while sample_ready is high; the stages hold on a stall.
// Writing the sample count starts a bit-serial reciprocal; sample_ready and
// cfg_ready stay low meanwhile. Reset loads a sample count of 100 and zero max speeds.
module point_to_point_profile_sampler import p2pps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  sample_t               sample,
	output logic                  point_valid,
	input  logic                  point_ready,
	output point_t                point,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [1:0] SHAPE_ZERO = 2'd0;
	localparam logic [1:0] SHAPE_RAMP = 2'd1;
	localparam logic [1:0] SHAPE_FLAT = 2'd2;

	logic [D_W-1:0]    d_q;
	logic [VMAX_W-1:0] vmax_q [AXES];

	logic               busy;
	logic [RECIP_W-1:0] recip;
	logic               cfg_wr;
	logic               recip_start;
	logic [N_W-1:0]     cfg_n;
	logic [D_W-1:0]     cfg_d;
	logic               adv;

	// config
	always_comb begin
		cfg_n = cfg_data[N_W-1:0];
		if (cfg_n < N_W'(2))
			cfg_d = D_W'(1);
		else if (cfg_n > N_W'(SAMPLE_LIMIT))
			cfg_d = D_W'(SAMPLE_LIMIT - 1);
		else
			cfg_d = D_W'(cfg_n - 1'b1);
	end

	assign cfg_ready   = !busy;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign recip_start = cfg_wr && (cfg_index == REG_SAMPLE_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= D_RESET;
			for (int k = 0; k < AXES; k++)
				vmax_q[k] <= '0;
		end else if (cfg_wr) begin
			if (cfg_index == REG_SAMPLE_COUNT)
				d_q <= cfg_d;
			else if (cfg_index inside {[REG_VMAX_FIRST:REG_VMAX_LAST]})
				vmax_q[CFG_IDX_W'(cfg_index - REG_VMAX_FIRST)] <= cfg_data[VMAX_W-1:0];
		end
	end

	p2pps_recip u_recip (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (recip_start),
		.divisor (cfg_d),
		.busy    (busy),
		.recip   (recip)
	);

	// pipeline control
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	assign adv          = !valid_s5 || point_ready;
	assign sample_ready = adv && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= sample_valid && sample_ready;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1: clamp index, normalized time, distance
	logic [D_W-1:0]         idx_c;
	logic [D_W+RECIP_W-1:0] t_prod;
	logic                   neg_c;
	logic [31:0]            ad_c;
	logic [VMAX_W-1:0]      vmax_c;

	logic [T_W-1:0]     t_s1;
	logic               neg_s1;
	logic [31:0]        ad_s1;
	logic [VMAX_W-1:0]  vmax_s1;
	logic [31:0]        dt_s1;
	logic signed [31:0] sp_s1;
	logic [31:0]        st_s1;

	always_comb begin
		idx_c  = (sample.point_index > d_q) ? d_q : sample.point_index;
		t_prod = idx_c * recip;
		neg_c  = sample.start_position > sample.end_position;
		ad_c   = neg_c ? 32'(sample.start_position - sample.end_position)
			: 32'(sample.end_position - sample.start_position);
		vmax_c = (sample.axis < AXIS_W'(AXES)) ? vmax_q[sample.axis] : '0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= t_prod[RECIP_SHIFT +: T_W];
			neg_s1  <= neg_c;
			ad_s1   <= ad_c;
			vmax_s1 <= vmax_c;
			dt_s1   <= sample.end_time - sample.start_time;
			sp_s1   <= sample.start_position;
			st_s1   <= sample.start_time;
		end
	end

	// stage 2: products and shape estimate
	logic [T_W-1:0]       u_full;
	logic [U_W-1:0]       u_c;
	logic [1:0]           sel_c;
	logic [U_W+SR_W-1:0]  q_prod;
	logic [T_W+31:0]      p_prod;
	logic [T_W+31:0]      tm_prod;
	logic [VMAX_W+31:0]   m_prod;

	logic [T_W+31:0]    pprod_s2;
	logic [31:0]        tstep_s2;
	logic [M_W-1:0]     m_s2;
	logic [U_W-1:0]     u_s2;
	logic [T_W-1:0]     q0_s2;
	logic [1:0]         sel_s2;
	logic               neg_s2;
	logic               big_s2;
	logic signed [31:0] sp_s2;
	logic [31:0]        st_s2;

	always_comb begin
		u_full = (t_s1 <= RAMP_EDGE) ? t_s1 : T_W'(FRAC_ONE - t_s1);
		u_c    = u_full[U_W-1:0];
		if (t_s1 == '0 || t_s1 >= FRAC_ONE)
			sel_c = SHAPE_ZERO;
		else if (t_s1 <= RAMP_EDGE || t_s1 > FLAT_END)
			sel_c = SHAPE_RAMP;
		else
			sel_c = SHAPE_FLAT;
		q_prod  = u_c * SHAPE_RECIP;
		p_prod  = t_s1 * ad_s1;
		tm_prod = t_s1 * dt_s1;
		m_prod  = vmax_s1 * ad_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pprod_s2 <= p_prod;
			tstep_s2 <= tm_prod[FRAC_BITS +: 32];
			m_s2     <= m_prod[16 +: M_W];
			u_s2     <= u_c;
			q0_s2    <= q_prod[FRAC_BITS +: T_W];
			sel_s2   <= sel_c;
			neg_s2   <= neg_s1;
			big_s2   <= ad_s1 > MIN_DIST;
			sp_s2    <= sp_s1;
			st_s2    <= st_s1;
		end
	end

	// stage 3: position, time, shape correction
	logic [32:0]         step_fl;
	logic [32:0]         step_c;
	logic signed [34:0]  pos_w;
	logic signed [31:0]  pos_c;
	logic [47:0]         qc;
	logic [47:0]         rem_c;
	logic [T_W-1:0]      s_ramp;
	logic [T_W-1:0]      s_c;

	logic signed [31:0] pos_s3;
	logic [31:0]        time_s3;
	logic [T_W-1:0]     s_s3;
	logic [M_W-1:0]     m_s3;
	logic               neg_s3;
	logic               big_s3;

	always_comb begin
		step_fl = pprod_s2[FRAC_BITS +: 33];
		step_c  = (neg_s2 && (|pprod_s2[FRAC_BITS-1:0])) ? step_fl + 1'b1 : step_fl;
		pos_w   = neg_s2 ? 35'(sp_s2) - $signed({2'b00, step_c})
			: 35'(sp_s2) + $signed({2'b00, step_c});
		if (pos_w > 35'sd2147483647)
			pos_c = 32'sh7fffffff;
		else if (pos_w < -35'sd2147483648)
			pos_c = 32'sh80000000;
		else
			pos_c = pos_w[31:0];

		qc     = 48'(q0_s2 * SHAPE_DIV);
		rem_c  = {1'b0, u_s2, {FRAC_BITS{1'b0}}} - qc;
		s_ramp = (rem_c >= 48'(SHAPE_DIV)) ? q0_s2 + 1'b1 : q0_s2;
		case (sel_s2)
			SHAPE_RAMP: s_c = s_ramp;
			SHAPE_FLAT: s_c = FRAC_ONE;
			default:    s_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s3  <= pos_c;
			time_s3 <= st_s2 + tstep_s2;
			s_s3    <= s_c;
			m_s3    <= m_s2;
			neg_s3  <= neg_s2;
			big_s3  <= big_s2;
		end
	end

	// stage 4: scale by shape, split in halves
	logic [M_W-FRAC_BITS+T_W-1:0] hi_c;
	logic [FRAC_BITS+T_W-1:0]     lo_c;

	logic [M_W-FRAC_BITS+T_W-1:0] hi_s4;
	logic [T_W-1:0]               lo_s4;
	logic                         neg_s4;
	logic                         big_s4;
	logic signed [31:0]           pos_s4;
	logic [31:0]                  time_s4;

	always_comb begin
		hi_c = m_s3[M_W-1:FRAC_BITS] * s_s3;
		lo_c = m_s3[FRAC_BITS-1:0] * s_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hi_s4   <= hi_c;
			lo_s4   <= lo_c[FRAC_BITS +: T_W];
			neg_s4  <= neg_s3;
			big_s4  <= big_s3;
			pos_s4  <= pos_s3;
			time_s4 <= time_s3;
		end
	end

	// stage 5: saturate, floor speed, sign
	logic [M_W-FRAC_BITS+T_W:0] mag_w;
	logic [VMAX_W-1:0]          mag_sat;
	logic [VMAX_W-1:0]          mag_c;
	logic signed [31:0]         vel_c;

	point_t point_s5;

	always_comb begin
		mag_w   = hi_s4 + lo_s4;
		mag_sat = (mag_w > 49'h7fffffff) ? {VMAX_W{1'b1}} : mag_w[VMAX_W-1:0];
		mag_c   = (big_s4 && mag_sat < MIN_SPEED) ? MIN_SPEED : mag_sat;
		vel_c   = neg_s4 ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_s5.position <= pos_s4;
			point_s5.velocity <= vel_c;
			point_s5.time_ms  <= time_s4;
		end
	end

	assign point_valid = valid_s5;
	assign point       = point_s5;

endmodule
